// ===== rtl/core/process_mailbox_engine_macros.svh =====
// Assertion helpers shared by the mailbox engine RTL.
// Each check samples on clk and is off while rst_n is low.
`ifndef PROCESS_MAILBOX_ENGINE_MACROS_SVH
`define PROCESS_MAILBOX_ENGINE_MACROS_SVH

// Same-cycle implication.
`define PME_CHECK_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PME_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/pme_pkg.sv =====
package pme_pkg;

  // fixed field widths
  localparam int OPC_W  = 2;
  localparam int ID_W   = 3;
  localparam int WORD_W = 32;
  localparam int CFG_W  = 4;
  localparam int STAT_W = 2;

  // opcodes
  localparam logic [OPC_W-1:0] OP_SEND      = 2'd0;
  localparam logic [OPC_W-1:0] OP_RECV_FROM = 2'd1;
  localparam logic [OPC_W-1:0] OP_RECV_ANY  = 2'd2;
  localparam logic [OPC_W-1:0] OP_SCHED     = 2'd3;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_BAD   = 2'd3;

  typedef struct packed {
    logic [OPC_W-1:0]  opcode;
    logic [ID_W-1:0]   target_id;
    logic [ID_W-1:0]   sender_filter;
    logic [WORD_W-1:0] payload;
  } pme_in_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [WORD_W-1:0] payload_out;
    logic [ID_W-1:0]   sender_out;
    logic [ID_W-1:0]   current_id;
  } pme_out_t;

endpackage

// ===== rtl/core/pme_mem.sv =====
// Simple dual-port RAM: one write port, one read port, registered read data.
module pme_mem #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 35,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/pme_ctrl.sv =====
`include "process_mailbox_engine_macros.svh"

// Operation sequencer: fill-count lookup, send append, receive scan with
// in-place compaction, round robin scheduling.
module pme_ctrl
  import pme_pkg::*;
#(
  parameter int MAX_PROCS    = 8,
  parameter int QUEUE_DEPTH  = 16,
  parameter int PAYLOAD_BITS = 32,
  localparam int PID_W   = $clog2(MAX_PROCS),
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1),
  localparam int DADDR_W = $clog2(MAX_PROCS * QUEUE_DEPTH),
  localparam int DWORD_W = PID_W + PAYLOAD_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  pme_in_t            in_data,
  output logic               busy,
  output logic               out_valid,
  output pme_out_t           out_data,
  input  logic [CFG_W-1:0]   ring,
  // fill-count memory
  output logic               cnt_we,
  output logic [PID_W-1:0]   cnt_waddr,
  output logic [CNT_W-1:0]   cnt_wdata,
  output logic [PID_W-1:0]   cnt_raddr,
  input  logic [CNT_W-1:0]   cnt_rdata,
  // slot memory
  output logic               dat_we,
  output logic [DADDR_W-1:0] dat_waddr,
  output logic [DWORD_W-1:0] dat_wdata,
  output logic [DADDR_W-1:0] dat_raddr,
  input  logic [DWORD_W-1:0] dat_rdata
);

  localparam int SLOT_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = (PID_W + 1 > CFG_W) ? PID_W + 1 : CFG_W;
  localparam int SW = (PID_W > ID_W) ? PID_W : ID_W;
  localparam int PW = (PAYLOAD_BITS > WORD_W) ? PAYLOAD_BITS : WORD_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CNT  = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;

  logic [1:0]              state_r, state_nxt;
  logic [PID_W-1:0]        cur_r, cur_nxt;
  logic [MAX_PROCS-1:0]    cnt_vld_r, cnt_vld_nxt;
  logic                    cvld_q_r, cvld_q_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    found_r, found_nxt;
  logic [OPC_W-1:0]        op_r, op_nxt;
  logic [ID_W-1:0]         filter_r, filter_nxt;
  logic [PAYLOAD_BITS-1:0] payload_r, payload_nxt;
  logic [PID_W-1:0]        pid_r, pid_nxt;
  logic [DADDR_W-1:0]      base_r, base_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [SLOT_W-1:0]       k_r, k_nxt;
  logic [PAYLOAD_BITS-1:0] got_payload_r, got_payload_nxt;
  logic [PID_W-1:0]        got_sender_r, got_sender_nxt;
  pme_out_t                out_r, out_nxt;

  logic [CW-1:0]           tgt_ext, cur_ext, nxt_ext, ring_ext;
  logic [PID_W-1:0]        pid_sel;
  logic [CNT_W-1:0]        cnt_now;
  logic [PID_W-1:0]        rd_sender;
  logic [PAYLOAD_BITS-1:0] rd_payload;
  logic                    match_now;
  logic                    last_slot;
  logic [PW-1:0]           in_pl_ext, out_pl_ext;
  logic [SW-1:0]           snd_ext, flt_ext, osnd_ext, ocur_ext;
  logic [PAYLOAD_BITS-1:0] sel_payload;
  logic [PID_W-1:0]        sel_sender;

  // operand shaping
  always_comb begin
    tgt_ext    = CW'(in_data.target_id);
    cur_ext    = CW'(cur_r);
    nxt_ext    = cur_ext + CW'(1);
    ring_ext   = CW'(ring);
    pid_sel    = (in_data.opcode == OP_SEND) ? tgt_ext[PID_W-1:0] : cur_r;
    in_pl_ext  = PW'(in_data.payload);
    cnt_now    = cvld_q_r ? cnt_rdata : '0;
    rd_sender  = dat_rdata[DWORD_W-1 -: PID_W];
    rd_payload = dat_rdata[PAYLOAD_BITS-1:0];
    snd_ext    = SW'(rd_sender);
    flt_ext    = SW'(filter_r);
    match_now  = (op_r == OP_RECV_ANY) || (snd_ext == flt_ext);
    last_slot  = (CNT_W'(k_r) == (cnt_r - CNT_W'(1)));
    sel_payload = found_r ? got_payload_r : rd_payload;
    sel_sender  = found_r ? got_sender_r : rd_sender;
    out_pl_ext = PW'(sel_payload);
    osnd_ext   = SW'(sel_sender);
  end

  // sequencer
  always_comb begin
    state_nxt       = state_r;
    cur_nxt         = cur_r;
    cnt_vld_nxt     = cnt_vld_r;
    cvld_q_nxt      = cvld_q_r;
    out_valid_nxt   = 1'b0;
    found_nxt       = found_r;
    op_nxt          = op_r;
    filter_nxt      = filter_r;
    payload_nxt     = payload_r;
    pid_nxt         = pid_r;
    base_nxt        = base_r;
    cnt_nxt         = cnt_r;
    k_nxt           = k_r;
    got_payload_nxt = got_payload_r;
    got_sender_nxt  = got_sender_r;
    out_nxt         = out_r;
    ocur_ext        = SW'(cur_r);

    cnt_we    = 1'b0;
    cnt_waddr = pid_r;
    cnt_wdata = '0;
    cnt_raddr = pid_sel;
    dat_we    = 1'b0;
    dat_waddr = base_r;
    dat_wdata = {cur_r, payload_r};
    dat_raddr = base_r;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          op_nxt      = in_data.opcode;
          filter_nxt  = in_data.sender_filter;
          payload_nxt = in_pl_ext[PAYLOAD_BITS-1:0];
          pid_nxt     = pid_sel;
          base_nxt    = DADDR_W'(pid_sel) * DADDR_W'(QUEUE_DEPTH);
          cvld_q_nxt  = cnt_vld_r[pid_sel];
          out_nxt.payload_out = '0;
          out_nxt.sender_out  = '0;
          if (in_data.opcode == OP_SCHED) begin
            // round robin advance, wraps at the ring size
            if (nxt_ext >= ring_ext) begin
              cur_nxt = '0;
            end else begin
              cur_nxt = nxt_ext[PID_W-1:0];
            end
            ocur_ext              = SW'(cur_nxt);
            out_nxt.status        = STAT_OK;
            out_nxt.current_id    = ocur_ext[ID_W-1:0];
            out_valid_nxt         = 1'b1;
          end else if (in_data.opcode == OP_SEND && tgt_ext >= ring_ext) begin
            out_nxt.status     = STAT_BAD;
            out_nxt.current_id = ocur_ext[ID_W-1:0];
            out_valid_nxt      = 1'b1;
          end else begin
            state_nxt = ST_CNT;
          end
        end
      end

      ST_CNT: begin
        out_nxt.current_id = ocur_ext[ID_W-1:0];
        if (op_r == OP_SEND) begin
          // append at the first free slot
          if (cnt_now == CNT_W'(QUEUE_DEPTH)) begin
            out_nxt.status = STAT_FULL;
          end else begin
            dat_we             = 1'b1;
            dat_waddr          = base_r + DADDR_W'(cnt_now);
            cnt_we             = 1'b1;
            cnt_wdata          = cnt_now + CNT_W'(1);
            cnt_vld_nxt[pid_r] = 1'b1;
            out_nxt.status     = STAT_OK;
          end
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else if (cnt_now == '0) begin
          out_nxt.status = STAT_EMPTY;
          out_valid_nxt  = 1'b1;
          state_nxt      = ST_IDLE;
        end else begin
          // start the scan at slot 0
          cnt_nxt   = cnt_now;
          k_nxt     = '0;
          found_nxt = 1'b0;
          dat_raddr = base_r;
          state_nxt = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // first match is captured, later slots move down by one
        if (!found_r && match_now) begin
          found_nxt       = 1'b1;
          got_payload_nxt = rd_payload;
          got_sender_nxt  = rd_sender;
        end
        if (found_r) begin
          dat_we    = 1'b1;
          dat_waddr = base_r + DADDR_W'(k_r) - DADDR_W'(1);
          dat_wdata = dat_rdata;
        end
        if (last_slot) begin
          out_nxt.current_id = ocur_ext[ID_W-1:0];
          if (found_r || match_now) begin
            cnt_we              = 1'b1;
            cnt_wdata           = cnt_r - CNT_W'(1);
            out_nxt.status      = STAT_OK;
            out_nxt.payload_out = out_pl_ext[WORD_W-1:0];
            out_nxt.sender_out  = osnd_ext[ID_W-1:0];
          end else begin
            out_nxt.status = STAT_EMPTY;
          end
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          k_nxt     = k_r + SLOT_W'(1);
          dat_raddr = base_r + DADDR_W'(k_r) + DADDR_W'(1);
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cur_r       <= '0;
      cnt_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      cnt_vld_r   <= cnt_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    cvld_q_r      <= cvld_q_nxt;
    found_r       <= found_nxt;
    op_r          <= op_nxt;
    filter_r      <= filter_nxt;
    payload_r     <= payload_nxt;
    pid_r         <= pid_nxt;
    base_r        <= base_nxt;
    cnt_r         <= cnt_nxt;
    k_r           <= k_nxt;
    got_payload_r <= got_payload_nxt;
    got_sender_r  <= got_sender_nxt;
    out_r         <= out_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `PME_CHECK_IMPL(a_strobe_idle, out_valid_r, state_r == ST_IDLE, "result strobe while busy")
  `PME_CHECK_NEXT(a_accept_moves, start && !busy, busy || out_valid_r, "transfer dropped")
  `PME_CHECK_IMPL(a_scan_bound, state_r == ST_SCAN, cnt_r != '0 && CNT_W'(k_r) < cnt_r, "scan past fill")

endmodule

// ===== rtl/core/process_mailbox_engine.sv =====
// Channel   Ports                          Transfer when
// -------   -----------------------------  ------------------------------
// input     start, busy, in_data           start high and busy low
// result    out_valid, out_data            out_valid high (one cycle)
// config    cfg_we, cfg_wdata              cfg_we high
//
// Send: the transfer passes through the fill-count state to the result strobe;
// bad receiver and schedule raise the strobe straight from idle. Receive: the
// fill-count state, then for a non-empty mailbox a scan with compaction, one
// slot per cycle through the slot memory's single read port, then the strobe.
// Reset (rst_n low, synchronous) empties all mailboxes at once through the
// per-process fill-valid bits; no clearing pass.
// Results cannot be stalled; the next item may be taken while a result shows.
module process_mailbox_engine
  import pme_pkg::*;
#(
  parameter int MAX_PROCS    = 8,
  parameter int QUEUE_DEPTH  = 16,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  pme_in_t          in_data,
  output logic             busy,
  output logic             out_valid,
  output pme_out_t         out_data,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int PID_W   = $clog2(MAX_PROCS);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int DADDR_W = $clog2(MAX_PROCS * QUEUE_DEPTH);
  localparam int DWORD_W = PID_W + PAYLOAD_BITS;

  logic [CFG_W-1:0]   process_count_r;
  logic [CFG_W-1:0]   ring;
  logic               cnt_we;
  logic [PID_W-1:0]   cnt_waddr, cnt_raddr;
  logic [CNT_W-1:0]   cnt_wdata, cnt_rdata;
  logic               dat_we;
  logic [DADDR_W-1:0] dat_waddr, dat_raddr;
  logic [DWORD_W-1:0] dat_wdata, dat_rdata;

  // process count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      process_count_r <= CFG_W'(1);
    end else if (cfg_we) begin
      process_count_r <= cfg_wdata;
    end
  end

  // effective ring size, clamped to 1..MAX_PROCS
  always_comb begin
    if (process_count_r == '0) begin
      ring = CFG_W'(1);
    end else if (32'(process_count_r) > MAX_PROCS) begin
      ring = CFG_W'(MAX_PROCS);
    end else begin
      ring = process_count_r;
    end
  end

  pme_ctrl #(
    .MAX_PROCS   (MAX_PROCS),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .PAYLOAD_BITS(PAYLOAD_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_data  (in_data),
    .busy     (busy),
    .out_valid(out_valid),
    .out_data (out_data),
    .ring     (ring),
    .cnt_we   (cnt_we),
    .cnt_waddr(cnt_waddr),
    .cnt_wdata(cnt_wdata),
    .cnt_raddr(cnt_raddr),
    .cnt_rdata(cnt_rdata),
    .dat_we   (dat_we),
    .dat_waddr(dat_waddr),
    .dat_wdata(dat_wdata),
    .dat_raddr(dat_raddr),
    .dat_rdata(dat_rdata)
  );

  // per-process fill counts
  pme_mem #(
    .DEPTH(MAX_PROCS),
    .WIDTH(CNT_W)
  ) u_cnt_mem (
    .clk  (clk),
    .we   (cnt_we),
    .waddr(cnt_waddr),
    .wdata(cnt_wdata),
    .raddr(cnt_raddr),
    .rdata(cnt_rdata)
  );

  // mailbox slots: {sender, payload}
  pme_mem #(
    .DEPTH(MAX_PROCS * QUEUE_DEPTH),
    .WIDTH(DWORD_W)
  ) u_slot_mem (
    .clk  (clk),
    .we   (dat_we),
    .waddr(dat_waddr),
    .wdata(dat_wdata),
    .raddr(dat_raddr),
    .rdata(dat_rdata)
  );

endmodule

// ===== tb/mailbox_checker.sv =====
`timescale 1ns / 100ps

// Watches the request, result and ring-size ports, keeps its own copy of the
// mailboxes and compares every result strobe against the oldest prediction.
module mailbox_checker
  import pme_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             busy,
  input  pme_in_t          in_data,
  input  logic             out_valid,
  input  pme_out_t         out_data,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  output int               errors,
  output int               outstanding
);

  localparam int PROCS = 8;
  localparam int DEPTH = 16;

  // compacted mailboxes: entries 0..fill-1 are live, oldest first
  logic [WORD_W-1:0] box_word [PROCS][DEPTH];
  logic [ID_W-1:0]   box_from [PROCS][DEPTH];
  int                box_fill [PROCS];
  logic [ID_W-1:0]   cur_proc;
  logic [CFG_W-1:0]  ring_cfg;
  pme_out_t          pending_replies [$];
  pme_out_t          want;

  initial errors = 0;

  // out-of-range counts clamp to 1..PROCS
  function automatic int ring_len();
    if (ring_cfg == 0) return 1;
    if (ring_cfg > PROCS) return PROCS;
    return int'(ring_cfg);
  endfunction

  // remove entry pos of mailbox p and close the gap
  function automatic void take_slot(int p, int pos);
    int k;
    for (k = pos; k + 1 < box_fill[p]; k++) begin
      box_word[p][k] = box_word[p][k + 1];
      box_from[p][k] = box_from[p][k + 1];
    end
    box_fill[p]--;
  endfunction

  // apply one request to the mailbox state, return the reply it causes
  function automatic pme_out_t mailbox_step(pme_in_t d);
    pme_out_t r;
    int       t;
    int       hit;
    int       k;
    int       nxt;
    r = '0;
    r.status = STAT_OK;
    t = int'(d.target_id);
    case (d.opcode)
      OP_SEND: begin
        if (t >= ring_len()) begin
          r.status = STAT_BAD;
        end else if (box_fill[t] == DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          box_word[t][box_fill[t]] = d.payload;
          box_from[t][box_fill[t]] = cur_proc;
          box_fill[t]++;
        end
      end
      OP_RECV_FROM: begin
        hit = -1;
        for (k = box_fill[cur_proc] - 1; k >= 0; k--)
          if (box_from[cur_proc][k] == d.sender_filter) hit = k;
        if (hit < 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.payload_out = box_word[cur_proc][hit];
          r.sender_out  = box_from[cur_proc][hit];
          take_slot(cur_proc, hit);
        end
      end
      OP_RECV_ANY: begin
        if (box_fill[cur_proc] == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.payload_out = box_word[cur_proc][0];
          r.sender_out  = box_from[cur_proc][0];
          take_slot(cur_proc, 0);
        end
      end
      default: begin
        // round robin; a pointer left beyond a shrunk ring wraps to 0
        nxt = cur_proc + 1;
        if (nxt >= ring_len()) nxt = 0;
        cur_proc = nxt[ID_W-1:0];
      end
    endcase
    r.current_id = cur_proc;
    return r;
  endfunction

  task automatic report(string what, logic [WORD_W-1:0] got, logic [WORD_W-1:0] exp_v);
    $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, exp_v);
    errors++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < PROCS; p++) box_fill[p] = 0;
      cur_proc = '0;
      ring_cfg = 4'd1;
      pending_replies.delete();
      outstanding <= 0;
    end else begin
      // result transfer: belongs to an earlier request
      if (out_valid) begin
        if (pending_replies.size() == 0) begin
          report("unrequested result status", WORD_W'(out_data.status), '0);
        end else begin
          want = pending_replies.pop_front();
          if (out_data.status !== want.status)
            report("status", WORD_W'(out_data.status), WORD_W'(want.status));
          if (out_data.payload_out !== want.payload_out)
            report("payload_out", out_data.payload_out, want.payload_out);
          if (out_data.sender_out !== want.sender_out)
            report("sender_out", WORD_W'(out_data.sender_out), WORD_W'(want.sender_out));
          if (out_data.current_id !== want.current_id)
            report("current_id", WORD_W'(out_data.current_id), WORD_W'(want.current_id));
        end
      end
      if (cfg_we) ring_cfg = cfg_wdata;
      // request transfer
      if (start && !busy) pending_replies.push_back(mailbox_step(in_data));
      outstanding <= pending_replies.size();
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import pme_pkg::*;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  pme_in_t          in_data;
  logic             out_valid;
  pme_out_t         out_data;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;
  int               errors;
  int               outstanding;
  bit               calm;

  // ring size per random phase, send share and request count
  int ring_seq [8] = '{1, 8, 15, 2, 0, 5, 9, 3};
  int send_seq [8] = '{60, 45, 55, 55, 50, 40, 35, 50};
  int len_seq  [8] = '{180, 250, 200, 180, 150, 200, 200, 170};

  process_mailbox_engine uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .busy      (busy),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  mailbox_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop
  initial begin
    #5000000;
    $display("Verification failed");
    $finish;
  end

  // one request transfer, with an occasional idle gap ahead of it
  task automatic issue(logic [OPC_W-1:0] op, int tgt, int flt, logic [WORD_W-1:0] word);
    pme_in_t d;
    d.opcode        = op;
    d.target_id     = tgt[ID_W-1:0];
    d.sender_filter = flt[ID_W-1:0];
    d.payload       = word;
    if (!calm && $urandom_range(99) < 13) begin
      start <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= d;
    do @(posedge clk); while (busy);
  endtask

  // hold off until every reply is back and the engine is quiet
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0 || busy);
  endtask

  task automatic set_ring(logic [CFG_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_phase(int n, int send_pct, int ring);
    int               r;
    int               rest;
    int               tgt;
    int               flt;
    logic [OPC_W-1:0] op;
    logic [WORD_W-1:0] word;
    rest = 100 - send_pct;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < send_pct) op = OP_SEND;
      else if (r < send_pct + rest * 2 / 5) op = OP_RECV_FROM;
      else if (r < send_pct + rest * 3 / 4) op = OP_RECV_ANY;
      else op = OP_SCHED;
      tgt = ($urandom_range(99) < 85) ? $urandom_range(ring - 1, 0) : $urandom_range(7, 0);
      flt = ($urandom_range(99) < 80) ? $urandom_range(ring - 1, 0) : $urandom_range(7, 0);
      r = $urandom_range(19);
      word = (r == 0) ? '0 : (r == 1) ? '1 : $urandom;
      issue(op, tgt, flt, word);
    end
  endtask

  initial begin
    int eff;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    calm      = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single process ring after reset: empty receives, bad target, order
    issue(OP_RECV_ANY, 0, 0, '0);
    issue(OP_RECV_FROM, 0, 3, '0);
    issue(OP_SEND, 7, 0, 32'h1234_5678);
    issue(OP_SEND, 0, 0, 32'h0000_0000);
    issue(OP_SEND, 0, 0, 32'hFFFF_FFFF);
    issue(OP_SCHED, 0, 0, '0);
    issue(OP_RECV_FROM, 0, 5, '0);
    issue(OP_RECV_FROM, 0, 0, '0);
    issue(OP_RECV_ANY, 0, 0, '0);
    settle();

    // full ring: walk to the last process and post to itself
    set_ring(4'd8);
    repeat (7) issue(OP_SCHED, 0, 0, '0);
    issue(OP_SEND, 7, 7, 32'hA5A5_5A5A);
    settle();

    // shrink the ring under the current process
    set_ring(4'd2);
    issue(OP_SEND, 7, 0, 32'h5A5A_A5A5);
    issue(OP_RECV_FROM, 0, 7, '0);
    issue(OP_SCHED, 0, 0, '0);
    settle();

    // random phases over several ring sizes, extremes included
    for (int ph = 0; ph < 8; ph++) begin
      set_ring(ring_seq[ph][CFG_W-1:0]);
      eff  = (ring_seq[ph] == 0) ? 1 : (ring_seq[ph] > 8) ? 8 : ring_seq[ph];
      calm = (ph == 5);
      run_phase(len_seq[ph], send_seq[ph], eff);
      settle();
    end

    repeat (25) @(posedge clk);
    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/pme_pkg.sv
rtl/core/pme_mem.sv
rtl/core/pme_ctrl.sv
rtl/core/process_mailbox_engine.sv
tb/mailbox_checker.sv
tb/tb.sv
